// ===== rtl/time_ordered_entry_list_unit_macros.svh =====
// assertion macros for the time ordered entry list unit
`ifndef TIME_ORDERED_ENTRY_LIST_UNIT_MACROS_SVH
`define TIME_ORDERED_ENTRY_LIST_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TOL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define TOL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TOL_ASSERT_IMP(lbl, ante, cons, msg)
`define TOL_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/tol_pkg.sv =====
// shared types and constants for the time ordered entry list unit
package tol_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int TIME_W      = 32;

  localparam logic [CNT_W-1:0] NO_NEIGHBOUR = CNT_W'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] MIN_IN_USE   = CNT_W'(1);

  // command codes
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd1;
  localparam logic [1:0] STATUS_BACKWARDS = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_CLEAR,
    S_REPORT
  } tol_state_t;

  // control strobes from the sequencer
  typedef struct packed {
    logic capture;
    logic shift;
    logic clear;
    logic report;
  } tol_ctl_t;

  // contents of one rank of the list
  typedef struct packed {
    logic [IDX_W-1:0]  id;
    logic [TIME_W-1:0] stamp;
    logic              seen;
  } tol_cell_data_t;

endpackage

// ===== rtl/tol_cell.sv =====
// one rank of the ordered list: holds an entry and moves it to its neighbors
module tol_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [tol_pkg::IDX_W-1:0]  cell_index,
  input  logic                    active,
  input  tol_pkg::tol_ctl_t       ctl,
  input  logic [tol_pkg::IDX_W-1:0]  key_entry,
  input  logic [tol_pkg::TIME_W-1:0] key_time,
  input  logic                    before_old,
  input  logic                    later_up,
  input  logic                    lt_prev,
  input  tol_pkg::tol_cell_data_t up_d,
  input  tol_pkg::tol_cell_data_t dn_d,
  output tol_pkg::tol_cell_data_t data_q,
  output logic                    later_o,
  output logic                    match_o,
  output logic                    back_o,
  output logic                    lt_o
);

  tol_pkg::tol_cell_data_t data_r, data_nxt;
  logic later_r, match_r, back_r;
  logic is_key, eq;

  assign is_key = (data_r.id == key_entry);

  // new rank lies above this cell / this cell takes the moved entry
  assign lt_o = before_old ? later_r : later_up;
  assign eq   = !lt_o && lt_prev;

  // next contents during the clear or shift step
  always_comb begin
    data_nxt = data_r;
    if (ctl.clear) begin
      data_nxt.id    = cell_index;
      data_nxt.stamp = '0;
      data_nxt.seen  = 1'b0;
    end else if (ctl.shift && active) begin
      if (lt_o) begin
        data_nxt = before_old ? data_r : up_d;
      end else if (eq) begin
        data_nxt.id    = key_entry;
        data_nxt.stamp = key_time;
        data_nxt.seen  = 1'b1;
      end else begin
        data_nxt = (before_old || match_r) ? dn_d : data_r;
      end
    end
  end

  // list contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r.id    <= cell_index;
      data_r.stamp <= '0;
      data_r.seen  <= 1'b0;
    end else begin
      data_r <= data_nxt;
    end
  end

  // compare flags taken in the search step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      later_r <= 1'b0;
      match_r <= 1'b0;
      back_r  <= 1'b0;
    end else if (ctl.capture) begin
      later_r <= active && !is_key && data_r.seen && (data_r.stamp > key_time);
      match_r <= active && is_key;
      back_r  <= active && is_key && data_r.seen && (key_time < data_r.stamp);
    end
  end

  assign data_q  = data_r;
  assign later_o = later_r;
  assign match_o = match_r;
  assign back_o  = back_r;

endmodule

// ===== rtl/tol_ctrl.sv =====
// command sequencer: search and shift, or clear, then report; a bad index goes straight to report
module tol_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              command,
  input  logic              bad_index,
  input  logic              back_any,
  output logic              busy,
  output tol_pkg::tol_ctl_t ctl
);

  tol_pkg::tol_state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tol_pkg::S_IDLE: begin
        if (start) begin
          if (command == tol_pkg::CMD_CLEAR) begin
            state_nxt = tol_pkg::S_CLEAR;
          end else if (bad_index) begin
            state_nxt = tol_pkg::S_REPORT;
          end else begin
            state_nxt = tol_pkg::S_SEARCH;
          end
        end
      end
      tol_pkg::S_SEARCH: state_nxt = tol_pkg::S_SHIFT;
      tol_pkg::S_SHIFT:  state_nxt = tol_pkg::S_REPORT;
      tol_pkg::S_CLEAR:  state_nxt = tol_pkg::S_REPORT;
      tol_pkg::S_REPORT: state_nxt = tol_pkg::S_IDLE;
      default:           state_nxt = tol_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy        = 1'b1;
    ctl.capture = 1'b0;
    ctl.shift   = 1'b0;
    ctl.clear   = 1'b0;
    ctl.report  = 1'b0;
    case (state_r)
      tol_pkg::S_IDLE:   busy = 1'b0;
      tol_pkg::S_SEARCH: ctl.capture = 1'b1;
      tol_pkg::S_SHIFT:  ctl.shift = !back_any;
      tol_pkg::S_CLEAR:  ctl.clear = 1'b1;
      tol_pkg::S_REPORT: ctl.report = 1'b1;
      default:           busy = 1'b1;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tol_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/time_ordered_entry_list_unit.sv =====
// time ordered entry list: top level with the cell chain and result register
// an update steps through search, shift and report, a clear through clear and report, and a bad
// index through report alone; the result is registered after the report step
// a new command is accepted only once the sequencer is back in idle
// reset: list order 0,1,2,... from the head, all entries never updated, 64 in use
// results cannot be stalled; busy stays high until the result strobe
`include "time_ordered_entry_list_unit_macros.svh"
module time_ordered_entry_list_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_command,
  input  logic [tol_pkg::IDX_W-1:0]    in_entry_index,
  input  logic [tol_pkg::TIME_W-1:0]   in_event_time,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [tol_pkg::IDX_W-1:0]    out_new_rank,
  output logic [tol_pkg::CNT_W-1:0]    out_older_neighbour,
  output logic [tol_pkg::CNT_W-1:0]    out_newer_neighbour,
  output logic [tol_pkg::IDX_W-1:0]    out_head_index,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tol_pkg::CNT_W-1:0]    cfg_entries_in_use
);

  localparam int N = tol_pkg::MAX_ENTRIES;

  logic                        accept, cfg_wr, bad_index, back_any;
  logic [tol_pkg::CNT_W-1:0]   in_use_r, in_use_nxt;
  logic                        cmd_r, bad_r;
  logic [tol_pkg::IDX_W-1:0]   entry_r;
  logic [tol_pkg::TIME_W-1:0]  stamp_r;
  tol_pkg::tol_ctl_t           ctl, cell_ctl;

  tol_pkg::tol_cell_data_t     cell_q [N];
  logic [N-1:0]                active, later, match, back, lt, before_old;
  logic [tol_pkg::IDX_W-1:0]   old_rank;

  logic                        out_valid_r;
  logic [1:0]                  status_r, status_nxt;
  logic [tol_pkg::IDX_W-1:0]   rank_r, rank_nxt, head_r;
  logic [tol_pkg::CNT_W-1:0]   older_r, older_nxt, newer_r, newer_nxt;
  logic [tol_pkg::IDX_W-1:0]   rep_entry;
  logic [N-1:0]                me;

  // handshakes; a register write never shares its edge with a command
  assign accept    = start && !busy;
  assign cfg_ready = !busy && !start;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign bad_index = ({1'b0, in_entry_index} >= in_use_r);

  // register write clamps to 1..MAX_ENTRIES
  always_comb begin
    in_use_nxt = cfg_entries_in_use;
    if (cfg_entries_in_use < tol_pkg::MIN_IN_USE) begin
      in_use_nxt = tol_pkg::MIN_IN_USE;
    end else if (cfg_entries_in_use > tol_pkg::NO_NEIGHBOUR) begin
      in_use_nxt = tol_pkg::NO_NEIGHBOUR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= tol_pkg::NO_NEIGHBOUR;
    end else if (cfg_wr) begin
      in_use_r <= in_use_nxt;
    end
  end

  // command fields held for the whole transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_command;
      bad_r   <= bad_index;
      entry_r <= in_entry_index;
      stamp_r <= in_event_time;
    end
  end

  tol_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .command   (in_command),
    .bad_index (bad_index),
    .back_any  (back_any),
    .busy      (busy),
    .ctl       (ctl)
  );

  // a register write also clears the list
  always_comb begin
    cell_ctl       = ctl;
    cell_ctl.clear = ctl.clear || cfg_wr;
  end

  assign back_any = |back;

  // old rank of the updated entry and which cells lie above it
  always_comb begin
    old_rank = '0;
    for (int r = 0; r < N; r++) begin
      if (match[r]) begin
        old_rank = old_rank | tol_pkg::IDX_W'(r);
      end
    end
    for (int r = 0; r < N; r++) begin
      before_old[r] = (tol_pkg::IDX_W'(r) < old_rank);
    end
  end

  // chain of rank cells
  for (genvar g = 0; g < N; g++) begin : g_cell
    tol_pkg::tol_cell_data_t up_d, dn_d;
    logic later_up, lt_prev;

    assign active[g] = (tol_pkg::CNT_W'(g) < in_use_r);

    if (g == N - 1) begin : g_last
      assign up_d     = '0;
      assign later_up = 1'b0;
    end else begin : g_mid
      assign up_d     = cell_q[g+1];
      assign later_up = later[g+1];
    end

    if (g == 0) begin : g_first
      assign dn_d    = '0;
      assign lt_prev = 1'b1;
    end else begin : g_rest
      assign dn_d    = cell_q[g-1];
      assign lt_prev = lt[g-1];
    end

    tol_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_index (tol_pkg::IDX_W'(g)),
      .active     (active[g]),
      .ctl        (cell_ctl),
      .key_entry  (entry_r),
      .key_time   (stamp_r),
      .before_old (before_old[g]),
      .later_up   (later_up),
      .lt_prev    (lt_prev),
      .up_d       (up_d),
      .dn_d       (dn_d),
      .data_q     (cell_q[g]),
      .later_o    (later[g]),
      .match_o    (match[g]),
      .back_o     (back[g]),
      .lt_o       (lt[g])
    );
  end

  // result: locate the reported entry and read its neighbors
  assign rep_entry = (cmd_r == tol_pkg::CMD_CLEAR) ? '0 : entry_r;

  always_comb begin
    for (int r = 0; r < N; r++) begin
      me[r] = active[r] && (cell_q[r].id == rep_entry);
    end
    rank_nxt  = '0;
    older_nxt = tol_pkg::NO_NEIGHBOUR;
    newer_nxt = tol_pkg::NO_NEIGHBOUR;
    for (int r = 0; r < N; r++) begin
      if (me[r]) begin
        rank_nxt = rank_nxt | tol_pkg::IDX_W'(r);
      end
    end
    for (int r = 0; r < N - 1; r++) begin
      if (me[r+1]) begin
        newer_nxt = {1'b0, cell_q[r].id};
      end
    end
    for (int r = 1; r < N; r++) begin
      if (me[r-1] && active[r]) begin
        older_nxt = {1'b0, cell_q[r].id};
      end
    end
    status_nxt = tol_pkg::STATUS_OK;
    if (cmd_r == tol_pkg::CMD_UPDATE) begin
      if (bad_r) begin
        status_nxt = tol_pkg::STATUS_BAD_INDEX;
        rank_nxt   = '0;
        older_nxt  = tol_pkg::NO_NEIGHBOUR;
        newer_nxt  = tol_pkg::NO_NEIGHBOUR;
      end else if (back_any) begin
        status_nxt = tol_pkg::STATUS_BACKWARDS;
      end
    end
  end

  // result register, shown for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.report;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.report) begin
      status_r <= status_nxt;
      rank_r   <= rank_nxt;
      older_r  <= older_nxt;
      newer_r  <= newer_nxt;
      head_r   <= cell_q[0].id;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_new_rank        = rank_r;
  assign out_older_neighbour = older_r;
  assign out_newer_neighbour = newer_r;
  assign out_head_index      = head_r;

  // checks
  `TOL_ASSERT_NXT(a_report_strobe, ctl.report, out_valid, "report step gave no result strobe")
  `TOL_ASSERT_IMP(a_strobe_idle, out_valid, !busy, "result strobe while still busy")
  `TOL_ASSERT_NXT(a_accept_busy, accept, busy, "accepted transaction did not raise busy")
  `TOL_ASSERT_IMP(a_single_match, 1'b1, $onehot0(match), "entry found at more than one rank")

endmodule
